FILE: sv/point_in_polygon_fixed_assert.svh
// assertion macros for the point-in-polygon geofence block
// uses the clock and reset names of the module that includes it
`ifndef POINT_IN_POLYGON_FIXED_ASSERT_SVH
`define POINT_IN_POLYGON_FIXED_ASSERT_SVH

// checked on every rising edge, switched off while reset is high
`define PIP_ASSERT_CLK(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// checked on every rising edge, reset included
`define PIP_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

FILE: sv/pip_pkg.sv
// shared widths, codes and types for the point-in-polygon geofence block
// no dependencies; compiled before the interfaces and modules
`timescale 1ns / 1ps
`default_nettype none

package pip_pkg;

   // default vertex store depth
   localparam int MAX_CORNERS_DEF = 64;

   // transaction field widths
   localparam int LAT_W    = 25;
   localparam int LON_W    = 26;
   localparam int IDX_IN_W = 6;
   localparam int COUNT_W  = 7;

   // datapath widths: differences, multiplier operands, product, compare
   localparam int DLAT_W = LAT_W + 1;
   localparam int DLON_W = LON_W + 1;
   localparam int OPND_W = DLON_W;
   localparam int PROD_W = 2 * OPND_W;
   localparam int ACC_W  = PROD_W + 2;

   // request kinds
   typedef enum logic {
      MODE_LOAD  = 1'b0,
      MODE_QUERY = 1'b1
   } mode_type;

   // steps of the shared arithmetic unit
   typedef enum logic [1:0] {
      OP_IDLE,
      OP_MUL_SLOPE,
      OP_MUL_CROSS,
      OP_DECIDE
   } op_type;

   // control from the sequencer to the arithmetic unit
   typedef struct packed {
      logic   clear;
      op_type op;
   } arith_ctl_type;

endpackage

`default_nettype wire

FILE: sv/pip_req_if.sv
// request channel: vertex loads and point queries
// depends on pip_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface pip_req_if;
   import pip_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       mode;
   logic [IDX_IN_W-1:0]        vertex_index;
   logic signed [LAT_W-1:0]    vertex_lat;
   logic signed [LON_W-1:0]    vertex_lon;
   logic signed [LAT_W-1:0]    query_lat;
   logic signed [LON_W-1:0]    query_lon;

   modport source (
      output valid, mode, vertex_index, vertex_lat, vertex_lon, query_lat, query_lon,
      input  ready
   );

   modport sink (
      input  valid, mode, vertex_index, vertex_lat, vertex_lon, query_lat, query_lon,
      output ready
   );
endinterface

`default_nettype wire

FILE: sv/pip_rsp_if.sv
// response channel: one inside/outside flag per query
// no package dependency
`timescale 1ns / 1ps
`default_nettype none

interface pip_rsp_if;
   logic valid;
   logic ready;
   logic inside_res;

   modport source (
      output valid, inside_res,
      input  ready
   );

   modport sink (
      input  valid, inside_res,
      output ready
   );
endinterface

`default_nettype wire

FILE: sv/point_in_polygon_fixed.sv
// even-odd ray-casting geofence: top level with vertex store and edge sequencer
// uses pip_pkg, pip_req_if, pip_rsp_if, pip_edge_unit and the assertion header
//
// a vertex load gives no response; ready is high only when idle
// a query walks n = min(corner_count, MAX_CORNERS) edges through one shared multiplier:
// a skipped edge passes S_EDGE, S_STEP and S_FETCH, a counted edge also S_MUL_SLOPE,
// S_MUL_CROSS and S_DECIDE; response valid next cycle when n is below 3; one query at a time
// synchronous reset clears the sequencer and corner_count; the vertex store is not cleared
`timescale 1ns / 1ps
`default_nettype none
`include "point_in_polygon_fixed_assert.svh"

module point_in_polygon_fixed #(
   parameter int MAX_CORNERS = pip_pkg::MAX_CORNERS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [pip_pkg::COUNT_W-1:0]   csr_wdata,
   pip_req_if.sink                            req_ch,
   pip_rsp_if.source                          rsp_ch
);
   import pip_pkg::*;

   localparam int IDX_W = $clog2(MAX_CORNERS);
   localparam int CNT_W = $clog2(MAX_CORNERS + 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_READ_PREV,
      S_TAKE_PREV,
      S_FETCH,
      S_EDGE,
      S_MUL_SLOPE,
      S_MUL_CROSS,
      S_DECIDE,
      S_STEP,
      S_DONE
   } state_type;

   state_type                state_ff;
   logic [COUNT_W-1:0]       csr_count_ff;
   logic [IDX_W-1:0]         addr_ff;
   logic [IDX_W-1:0]         last_ff;
   logic signed [LAT_W-1:0]  q_lat_ff;
   logic signed [LON_W-1:0]  q_lon_ff;
   logic signed [LAT_W-1:0]  prev_lat_ff;
   logic signed [LON_W-1:0]  prev_lon_ff;
   logic signed [LAT_W-1:0]  cur_lat_ff;
   logic signed [LON_W-1:0]  cur_lon_ff;
   logic signed [LAT_W-1:0]  rd_lat_ff;
   logic signed [LON_W-1:0]  rd_lon_ff;

   logic signed [LAT_W-1:0]  lat_mem [MAX_CORNERS];
   logic signed [LON_W-1:0]  lon_mem [MAX_CORNERS];

   logic [CNT_W-1:0]         corner_n;
   logic [IDX_W-1:0]         last_idx;
   logic                     too_few;
   logic                     req_accept;
   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic                     straddle;
   logic                     west;
   arith_ctl_type            arith_ctl;
   logic                     inside_flag;

   // corner count register
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_count_ff <= '0;
      end else if (csr_we) begin
         csr_count_ff <= csr_wdata;
      end
   end

   // saturated corner count and index of the last vertex
   always_comb begin
      if (int'(csr_count_ff) > MAX_CORNERS) begin
         corner_n = CNT_W'(MAX_CORNERS);
      end else begin
         corner_n = CNT_W'(csr_count_ff);
      end
   end

   assign too_few  = corner_n < CNT_W'(3);
   assign last_idx = IDX_W'(corner_n - CNT_W'(1));

   // handshakes
   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid = (state_ff == S_DONE);
   assign rsp_ch.inside_res = inside_flag;

   // vertex store: one write port for loads, one registered read port for the walk
   assign wr_en   = req_accept && (req_ch.mode == MODE_LOAD)
                    && (int'(req_ch.vertex_index) < MAX_CORNERS);
   assign wr_addr = IDX_W'(req_ch.vertex_index);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         lat_mem[wr_addr] <= req_ch.vertex_lat;
         lon_mem[wr_addr] <= req_ch.vertex_lon;
      end
      rd_lat_ff <= lat_mem[addr_ff];
      rd_lon_ff <= lon_mem[addr_ff];
   end

   // edge test on the freshly read vertex against the previous one
   assign straddle = ((rd_lat_ff < q_lat_ff) && (prev_lat_ff >= q_lat_ff))
                  || ((prev_lat_ff < q_lat_ff) && (rd_lat_ff >= q_lat_ff));
   assign west     = (rd_lon_ff <= q_lon_ff) || (prev_lon_ff <= q_lon_ff);

   // steps for the shared arithmetic unit
   always_comb begin
      arith_ctl.clear = req_accept && (req_ch.mode == MODE_QUERY);
      case (state_ff)
         S_MUL_SLOPE: arith_ctl.op = OP_MUL_SLOPE;
         S_MUL_CROSS: arith_ctl.op = OP_MUL_CROSS;
         S_DECIDE:    arith_ctl.op = OP_DECIDE;
         default:     arith_ctl.op = OP_IDLE;
      endcase
   end

   pip_edge_unit u_edge (
      .clock       (clock),
      .ctl         (arith_ctl),
      .q_lat       (q_lat_ff),
      .q_lon       (q_lon_ff),
      .cur_lat     (cur_lat_ff),
      .cur_lon     (cur_lon_ff),
      .prev_lat    (prev_lat_ff),
      .prev_lon    (prev_lon_ff),
      .inside_flag (inside_flag)
   );

   // edge walk sequencer: last vertex first, then vertices 0 .. n-1
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_accept && (req_ch.mode == MODE_QUERY)) begin
                  q_lat_ff <= req_ch.query_lat;
                  q_lon_ff <= req_ch.query_lon;
                  addr_ff  <= last_idx;
                  last_ff  <= last_idx;
                  state_ff <= too_few ? S_DONE : S_READ_PREV;
               end
            end
            S_READ_PREV: begin
               addr_ff  <= '0;
               state_ff <= S_TAKE_PREV;
            end
            S_TAKE_PREV: begin
               prev_lat_ff <= rd_lat_ff;
               prev_lon_ff <= rd_lon_ff;
               state_ff    <= S_EDGE;
            end
            S_FETCH: begin
               state_ff <= S_EDGE;
            end
            S_EDGE: begin
               cur_lat_ff <= rd_lat_ff;
               cur_lon_ff <= rd_lon_ff;
               state_ff   <= (straddle && west) ? S_MUL_SLOPE : S_STEP;
            end
            S_MUL_SLOPE: begin
               state_ff <= S_MUL_CROSS;
            end
            S_MUL_CROSS: begin
               state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               state_ff <= S_STEP;
            end
            S_STEP: begin
               prev_lat_ff <= cur_lat_ff;
               prev_lon_ff <= cur_lon_ff;
               if (addr_ff == last_ff) begin
                  state_ff <= S_DONE;
               end else begin
                  addr_ff  <= addr_ff + IDX_W'(1);
                  state_ff <= S_FETCH;
               end
            end
            S_DONE: begin
               if (rsp_ch.ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // checks
   `PIP_ASSERT_CLK(a_few_corners_outside,
      (req_accept && (req_ch.mode == MODE_QUERY) && too_few)
         |=> ((state_ff == S_DONE) && !rsp_ch.inside_res),
      "query with fewer than three corners did not answer outside at once")
   `PIP_ASSERT_CLK(a_load_stays_idle,
      (req_accept && (req_ch.mode == MODE_LOAD)) |=> (state_ff == S_IDLE),
      "vertex load left the idle state")
   `PIP_ASSERT_CLK(a_walk_in_range,
      (state_ff == S_EDGE) |-> (addr_ff <= last_ff),
      "edge walk ran past the last vertex")
   `PIP_ASSERT_CLK(a_decide_after_cross,
      (arith_ctl.op == OP_DECIDE) |-> ($past(arith_ctl.op) == OP_MUL_CROSS),
      "crossing decision taken without the cross product")
   `PIP_ASSERT_ALWAYS(a_reset_no_response,
      $past(reset) |-> !rsp_ch.valid,
      "response valid straight after reset")

endmodule

`default_nettype wire

FILE: sv/pip_edge_unit.sv
// shared multiplier and crossing decision for one polygon edge at a time
// depends on pip_pkg; driven step by step by the top-level sequencer
`timescale 1ns / 1ps
`default_nettype none

module pip_edge_unit (
   input  wire logic                          clock,
   input  wire pip_pkg::arith_ctl_type        ctl,
   input  wire logic signed [pip_pkg::LAT_W-1:0] q_lat,
   input  wire logic signed [pip_pkg::LON_W-1:0] q_lon,
   input  wire logic signed [pip_pkg::LAT_W-1:0] cur_lat,
   input  wire logic signed [pip_pkg::LON_W-1:0] cur_lon,
   input  wire logic signed [pip_pkg::LAT_W-1:0] prev_lat,
   input  wire logic signed [pip_pkg::LON_W-1:0] prev_lon,
   output logic                               inside_flag
);
   import pip_pkg::*;

   logic signed [DLAT_W-1:0] dlat;
   logic signed [DLAT_W-1:0] den;
   logic signed [DLON_W-1:0] dlon_edge;
   logic signed [DLON_W-1:0] dlon_q;
   logic signed [OPND_W-1:0] den_ext;
   logic signed [OPND_W-1:0] op_a;
   logic signed [OPND_W-1:0] op_b;
   logic signed [PROD_W-1:0] mul_out;
   logic signed [ACC_W-1:0]  prod_ext;
   logic signed [ACC_W-1:0]  num_in;
   logic signed [ACC_W-1:0]  bound_neg;
   logic                     toggle;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  num_ff;
   logic signed [OPND_W-1:0] abs_den_ff;
   logic                     den_neg_ff;
   logic                     inside_ff;

   // edge differences
   assign dlat      = DLAT_W'(q_lat) - DLAT_W'(cur_lat);
   assign den       = DLAT_W'(prev_lat) - DLAT_W'(cur_lat);
   assign dlon_edge = DLON_W'(prev_lon) - DLON_W'(cur_lon);
   assign dlon_q    = DLON_W'(q_lon) - DLON_W'(cur_lon);
   assign den_ext   = OPND_W'(den);

   // operand select for the one multiplier
   always_comb begin
      case (ctl.op)
         OP_MUL_CROSS: begin
            op_a = dlon_q;
            op_b = abs_den_ff;
         end
         default: begin
            op_a = OPND_W'(dlat);
            op_b = dlon_edge;
         end
      endcase
   end

   assign mul_out = op_a * op_b;

   // slope product with the sign of the divisor folded in
   assign prod_ext = ACC_W'(prod_ff);
   assign num_in   = den_neg_ff ? -prod_ext : prod_ext;

   // truncated quotient below the offset: floor side for a non-negative
   // numerator, ceiling side (one divisor lower) for a negative one
   assign bound_neg = prod_ext - ACC_W'(abs_den_ff);
   assign toggle    = num_ff[ACC_W-1] ? (num_ff <= bound_neg) : (num_ff < prod_ext);

   // product, divisor magnitude and inside flag
   always_ff @(posedge clock) begin
      case (ctl.op)
         OP_MUL_SLOPE: begin
            prod_ff    <= mul_out;
            den_neg_ff <= den[DLAT_W-1];
            abs_den_ff <= den[DLAT_W-1] ? -den_ext : den_ext;
         end
         OP_MUL_CROSS: begin
            num_ff  <= num_in;
            prod_ff <= mul_out;
         end
         OP_DECIDE: begin
            inside_ff <= inside_ff ^ toggle;
         end
         default: begin
         end
      endcase
      if (ctl.clear) begin
         inside_ff <= 1'b0;
      end
   end

   assign inside_flag = inside_ff;

endmodule

`default_nettype wire

FILE: dv/tb.sv
// testbench for the point-in-polygon geofence block: vertex loads, point queries, corner count
// self-checking against an in-bench ray-casting predictor; needs pip_pkg, the channel
// interfaces and point_in_polygon_fixed
`timescale 1ns / 1ps

module tb;
   import pip_pkg::*;

   localparam int DEPTH        = MAX_CORNERS_DEF;
   localparam int CLOCK_HALF   = 4;
   localparam int RESET_CYCLES = 8;
   localparam int LIMIT_CYCLES = 1000000;
   localparam int RANDOM_ITEMS = 270;
   localparam int IDLE_PCT     = 9;
   localparam int HOLD_CYCLES  = 600;
   localparam int SETTLE_LOAD  = 4;
   localparam int DRAIN_CYCLES = 6 * DEPTH + 20;
   localparam int LAT_MAX      = 9000000;
   localparam int LON_MAX      = 18000000;

   // one request transaction as seen on the channel
   typedef struct {
      mode_type                mode;
      logic [IDX_IN_W-1:0]     vertex_index;
      logic signed [LAT_W-1:0] vertex_lat;
      logic signed [LON_W-1:0] vertex_lon;
      logic signed [LAT_W-1:0] query_lat;
      logic signed [LON_W-1:0] query_lon;
   } geo_transaction_type;

   // vertex store, corner count and the queue of inside flags still owed
   class geofence_scoreboard;
      longint      lat_mem[DEPTH];
      longint      lon_mem[DEPTH];
      int unsigned corner_count;
      bit          inside_due[$];
      int          mismatches;

      function void set_corner_count(logic [COUNT_W-1:0] value);
         corner_count = 32'(value);
      endfunction

      // even-odd crossing count along a ray running west of the point
      function bit ray_cast_inside(longint qlat, longint qlon);
         int     n;
         int     c;
         int     p;
         bit     in_poly;
         longint latc, lonc, latp, lonp, cross_lon;
         n = (corner_count > DEPTH) ? DEPTH : corner_count;
         in_poly = 1'b0;
         if (n < 3) return 1'b0;
         p = n - 1;
         for (c = 0; c < n; c++) begin
            latc = lat_mem[c];
            lonc = lon_mem[c];
            latp = lat_mem[p];
            lonp = lon_mem[p];
            if (((latc < qlat && latp >= qlat) || (latp < qlat && latc >= qlat)) &&
                (lonc <= qlon || lonp <= qlon)) begin
               // full product first, then truncating division
               cross_lon = lonc + ((qlat - latc) * (lonp - lonc)) / (latp - latc);
               if (cross_lon < qlon) in_poly = ~in_poly;
            end
            p = c;
         end
         return in_poly;
      endfunction

      function void note_request(geo_transaction_type t);
         if (t.mode == MODE_LOAD) begin
            if (t.vertex_index < DEPTH) begin
               lat_mem[t.vertex_index] = longint'(t.vertex_lat);
               lon_mem[t.vertex_index] = longint'(t.vertex_lon);
            end
         end else begin
            inside_due.push_back(ray_cast_inside(longint'(t.query_lat),
                                                 longint'(t.query_lon)));
         end
      endfunction

      function void check_inside(logic actual);
         bit expected;
         if (inside_due.size() == 0) begin
            $error("inside_res: no query pending, actual %0b", actual);
            mismatches++;
            return;
         end
         expected = inside_due.pop_front();
         if (actual !== expected) begin
            $error("inside_res mismatch: expected %0b, actual %0b", expected, actual);
            mismatches++;
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [COUNT_W-1:0]   csr_wdata;
   pip_req_if            req_ch();
   pip_rsp_if            rsp_ch();

   geofence_scoreboard   sb = new();
   bit                   steady;
   bit                   hold_trigger;
   bit                   hold_done;
   int                   hold_count;
   int                   random_items;
   int                   cycle_count;

   point_in_polygon_fixed #(.MAX_CORNERS(DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   // clock
   always begin
      clock = 1'b0;
      #CLOCK_HALF;
      clock = 1'b1;
      #CLOCK_HALF;
   end

   // watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $error("timeout after %0d cycles", cycle_count);
      $display("point_in_polygon_fixed test failed");
      $finish;
   end

   // response side: random stalls, one long hold-off, none while steady
   always @(negedge clock) begin
      if (hold_trigger && !hold_done) begin
         rsp_ch.ready <= 1'b0;
         hold_count++;
         if (hold_count >= HOLD_CYCLES) hold_done = 1'b1;
      end else if (steady) begin
         rsp_ch.ready <= 1'b1;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // observe accepted transactions on both channels
   always @(posedge clock) begin
      geo_transaction_type seen;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            seen.mode         = mode_type'(req_ch.mode);
            seen.vertex_index = req_ch.vertex_index;
            seen.vertex_lat   = req_ch.vertex_lat;
            seen.vertex_lon   = req_ch.vertex_lon;
            seen.query_lat    = req_ch.query_lat;
            seen.query_lon    = req_ch.query_lon;
            sb.note_request(seen);
         end
         if (rsp_ch.valid && rsp_ch.ready) sb.check_inside(rsp_ch.inside_res);
      end
   end

   // offer one transaction, with random gaps, and wait for acceptance
   task automatic send(input geo_transaction_type t);
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.mode         <= t.mode;
      req_ch.vertex_index <= t.vertex_index;
      req_ch.vertex_lat   <= t.vertex_lat;
      req_ch.vertex_lon   <= t.vertex_lon;
      req_ch.query_lat    <= t.query_lat;
      req_ch.query_lon    <= t.query_lon;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // register write once the block has gone quiet
   task automatic write_corner_count(input int value);
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (sb.inside_due.size() != 0) @(posedge clock);
      repeat (SETTLE_LOAD) @(posedge clock);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value[COUNT_W-1:0];
      @(negedge clock);
      csr_we    <= 1'b0;
      sb.set_corner_count(value[COUNT_W-1:0]);
   endtask

   // unused fields carry random bits
   function automatic geo_transaction_type load_txn(input int slot, input int lat, input int lon);
      geo_transaction_type t;
      t.mode         = MODE_LOAD;
      t.vertex_index = IDX_IN_W'(slot);
      t.vertex_lat   = LAT_W'(lat);
      t.vertex_lon   = LON_W'(lon);
      t.query_lat    = LAT_W'($urandom);
      t.query_lon    = LON_W'($urandom);
      return t;
   endfunction

   function automatic geo_transaction_type query_txn(input int lat, input int lon);
      geo_transaction_type t;
      t.mode         = MODE_QUERY;
      t.vertex_index = IDX_IN_W'($urandom);
      t.vertex_lat   = LAT_W'($urandom);
      t.vertex_lon   = LON_W'($urandom);
      t.query_lat    = LAT_W'(lat);
      t.query_lon    = LON_W'(lon);
      return t;
   endfunction

   function automatic int around(input int centre, input int span);
      return centre + int'($urandom_range(0, 2 * span)) - span;
   endfunction

   // a polygon of random vertices about one centre, then queries near it
   task automatic run_phase(input int count, input bit hold_rsp);
      int used, k, slot, c_lat, c_lon, span, lat, lon, pick, queries;
      int vlat[DEPTH];
      int vlon[DEPTH];
      write_corner_count(count);
      used  = (count > DEPTH) ? DEPTH : count;
      c_lat = int'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX;
      c_lon = int'($urandom_range(0, 2 * LON_MAX)) - LON_MAX;
      case ($urandom_range(0, 3))
         0: span = 50;
         1: span = 5000;
         2: span = 500000;
         default: span = 3000000;
      endcase
      for (k = 0; k < used; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            // raw bit patterns, out of range included
            vlat[k] = $urandom;
            vlon[k] = $urandom;
         end else if (pick < 20 && k > 0) begin
            // flat edge
            vlat[k] = vlat[k-1];
            vlon[k] = around(c_lon, span);
         end else begin
            vlat[k] = around(c_lat, span);
            vlon[k] = around(c_lon, span);
         end
         send(load_txn(k, vlat[k], vlon[k]));
         random_items++;
      end
      if (hold_rsp) hold_trigger = 1'b1;
      queries = (used > 16) ? 6 : $urandom_range(6, 16);
      for (k = 0; k < queries; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            // move one vertex between queries
            slot = (used > 0) ? $urandom_range(0, used - 1) : $urandom_range(0, DEPTH - 1);
            vlat[slot] = around(c_lat, span);
            vlon[slot] = around(c_lon, span);
            send(load_txn(slot, vlat[slot], vlon[slot]));
         end else begin
            if (pick < 20) begin
               lat = $urandom;
               lon = $urandom;
            end else begin
               lat = around(c_lat, span);
               lon = around(c_lon, span);
               // land on vertex latitudes and longitudes
               if (used > 0 && pick < 45) lat = vlat[$urandom_range(0, used - 1)];
               if (used > 0 && pick >= 35 && pick < 55) lon = vlon[$urandom_range(0, used - 1)];
            end
            send(query_txn(lat, lon));
         end
         random_items++;
      end
   endtask

   function automatic int pick_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return $urandom_range(0, 2);
      if (r < 13) return DEPTH;
      if (r < 16) return $urandom_range(DEPTH + 1, 127);
      return $urandom_range(3, 12);
   endfunction

   initial begin
      int phase;
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_wdata           = '0;
      req_ch.valid        = 1'b0;
      req_ch.mode         = MODE_LOAD;
      req_ch.vertex_index = '0;
      req_ch.vertex_lat   = '0;
      req_ch.vertex_lon   = '0;
      req_ch.query_lat    = '0;
      req_ch.query_lon    = '0;
      rsp_ch.ready        = 1'b0;
      random_items        = 0;
      sb.set_corner_count('0);
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // too few corners: nothing counts, no vertex is read
      write_corner_count(0);
      send(query_txn(-LAT_MAX, -LON_MAX));
      send(query_txn(LAT_MAX, LON_MAX));
      write_corner_count(1);
      send(load_txn(0, -LAT_MAX, -LON_MAX));
      send(query_txn(0, 0));
      write_corner_count(2);
      send(load_txn(1, LAT_MAX, 0));
      send(query_txn(0, LON_MAX));

      // full-range triangle, boundary points and raw extremes
      write_corner_count(3);
      send(load_txn(2, -LAT_MAX, LON_MAX));
      send(query_txn(0, 0));
      send(query_txn(0, -LON_MAX + 1));
      send(query_txn(0, -LON_MAX / 2));
      send(query_txn(-LAT_MAX, 0));
      send(query_txn(LAT_MAX, 0));
      send(query_txn(0, LON_MAX));
      send(query_txn(16777215, -33554432));
      send(query_txn(-16777216, 33554431));

      // random polygons; count above the store first, then the long hold-off
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         steady = (phase == 3 || phase == 4);
         case (phase)
            0: run_phase(127, 1'b0);
            1: run_phase(3, 1'b1);
            2: run_phase(DEPTH, 1'b0);
            default: run_phase(pick_count(), 1'b0);
         endcase
         phase++;
      end
      steady = 1'b0;

      // drain
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (sb.inside_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.mismatches == 0 && sb.inside_due.size() == 0) begin
         $display("point_in_polygon_fixed test passed");
      end else begin
         $display("point_in_polygon_fixed test failed");
      end
      $finish;
   end

endmodule
